// ===== sv/rhm_pkg.sv =====
// ----------------------------------------------------------------------------
// rhm_pkg
// Shared types and constants for the red hue mask / bounding box block.
// ----------------------------------------------------------------------------
package rhm_pkg;

	localparam int COORD_BITS  = 12;
	localparam int COUNT_BITS  = 24;
	localparam int SAMPLE_BITS = 8;

	localparam int COS_BITS    = 16;
	localparam int MIN_BITS    = 24;
	localparam int TENTHS_BITS = 8;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_IDX_W   = 3;

	// hue datapath widths
	localparam int DIFF_W  = SAMPLE_BITS + 1;
	localparam int N2_W    = SAMPLE_BITS + 2;
	localparam int SQ_W    = 2 * SAMPLE_BITS;
	localparam int PX_W    = 2 * SAMPLE_BITS + 1;
	localparam int SUM_W   = 2 * SAMPLE_BITS + 2;
	localparam int NSQ_W   = 2 * N2_W - 2;
	localparam int NSQ_EXT = 2 * N2_W;
	localparam int PROD_W  = COS_BITS + SQ_W;
	localparam int LHS_SH  = COS_BITS - 2;

	// aspect datapath width
	localparam int SPAN_W = COORD_BITS + 1;
	localparam int ASP_W  = SPAN_W + TENTHS_BITS + 1;
	localparam int CNT_CMP_W = (COUNT_BITS > MIN_BITS) ? COUNT_BITS : MIN_BITS;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [COS_BITS-1:0]    RST_COS_SQ_LOW  = COS_BITS'(63668);
	localparam logic [COS_BITS-1:0]    RST_COS_SQ_HIGH = COS_BITS'(16265);
	localparam logic [MIN_BITS-1:0]    RST_MIN_MATCHES = MIN_BITS'(30);
	localparam logic [TENTHS_BITS-1:0] RST_ASPECT_HIGH = TENTHS_BITS'(12);
	localparam logic [TENTHS_BITS-1:0] RST_ASPECT_LOW  = TENTHS_BITS'(9);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COS_SQ_LOW_HUE     = 3'd0,
		CFG_COS_SQ_HIGH_HUE    = 3'd1,
		CFG_MIN_MATCHES        = 3'd2,
		CFG_ASPECT_HIGH_TENTHS = 3'd3,
		CFG_ASPECT_LOW_TENTHS  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [COS_BITS-1:0]    cos_sq_low_hue;
		logic [COS_BITS-1:0]    cos_sq_high_hue;
		logic [MIN_BITS-1:0]    min_matches;
		logic [TENTHS_BITS-1:0] aspect_high_tenths;
		logic [TENTHS_BITS-1:0] aspect_low_tenths;
	} cfg_t;

	typedef struct packed {
		logic                  mark;
		logic                  eof;
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
	} item_t;

endpackage

// ===== sv/rhm_front.sv =====
// ----------------------------------------------------------------------------
// rhm_front
// Three-stage hue classifier: squared-cosine test on the RGB sample, one
// pixel per clock, stalls as a whole when the queue is full.
// ----------------------------------------------------------------------------
module rhm_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rhm_pkg::COORD_BITS-1:0] pixel_row,
	input  logic [rhm_pkg::COORD_BITS-1:0] pixel_col,
	input  logic [rhm_pkg::SAMPLE_BITS-1:0] red,
	input  logic [rhm_pkg::SAMPLE_BITS-1:0] green,
	input  logic [rhm_pkg::SAMPLE_BITS-1:0] blue,
	input  logic                           end_of_frame,
	input  rhm_pkg::cfg_t                  cfg,
	output logic                           q_push,
	output rhm_pkg::item_t                 q_item,
	input  logic                           q_ready
);
	import rhm_pkg::*;

	logic en;

	logic signed [DIFF_W-1:0] rg, rb, gb;
	logic signed [SUM_W-1:0]  sq_full, px_full;
	logic signed [N2_W-1:0]   n2;
	logic signed [SUM_W-1:0]  d2_sum;
	logic signed [NSQ_EXT-1:0] nsq_full;

	// stage 1
	logic                     v_s1;
	logic [SQ_W-1:0]          prg_s1;
	logic signed [PX_W-1:0]   px_s1;
	logic signed [N2_W-1:0]   n2_s1;
	logic                     bgt_s1;
	logic                     eof_s1;
	logic [COORD_BITS-1:0]    row_s1, col_s1;

	// stage 2
	logic                     v_s2;
	logic [SQ_W-1:0]          d2_s2;
	logic [NSQ_W-1:0]         nsq_s2;
	logic                     nneg_s2;
	logic [COS_BITS-1:0]      thr_s2;
	logic                     eof_s2;
	logic [COORD_BITS-1:0]    row_s2, col_s2;

	// stage 3
	logic                     v_s3;
	logic [PROD_W-1:0]        rhs_s3, lhs_s3;
	logic                     dz_s3, nneg_s3;
	logic                     eof_s3;
	logic [COORD_BITS-1:0]    row_s3, col_s3;

	assign en       = !v_s3 || q_ready;
	assign in_ready = en;

	assign rg = $signed({1'b0, red})   - $signed({1'b0, green});
	assign rb = $signed({1'b0, red})   - $signed({1'b0, blue});
	assign gb = $signed({1'b0, green}) - $signed({1'b0, blue});
	assign sq_full = SUM_W'(rg) * SUM_W'(rg);
	assign px_full = SUM_W'(rb) * SUM_W'(gb);
	assign n2 = N2_W'(rg) + N2_W'(rb);

	assign d2_sum   = $signed({2'b00, prg_s1}) + SUM_W'(px_s1);
	assign nsq_full = NSQ_EXT'(n2_s1) * NSQ_EXT'(n2_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prg_s1  <= sq_full[SQ_W-1:0];
			px_s1   <= px_full[PX_W-1:0];
			n2_s1   <= n2;
			bgt_s1  <= blue > green;
			eof_s1  <= end_of_frame;
			row_s1  <= pixel_row;
			col_s1  <= pixel_col;

			d2_s2   <= d2_sum[SQ_W-1:0];
			nsq_s2  <= nsq_full[NSQ_W-1:0];
			nneg_s2 <= n2_s1[N2_W-1];
			thr_s2  <= bgt_s1 ? cfg.cos_sq_high_hue : cfg.cos_sq_low_hue;
			eof_s2  <= eof_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;

			rhs_s3  <= PROD_W'(thr_s2) * PROD_W'(d2_s2);
			lhs_s3  <= {nsq_s2, LHS_SH'(0)};
			dz_s3   <= d2_s2 == '0;
			nneg_s3 <= nneg_s2;
			eof_s3  <= eof_s2;
			row_s3  <= row_s2;
			col_s3  <= col_s2;
		end
	end

	// achromatic pixels count as hue 0
	assign q_push      = v_s3 && q_ready;
	assign q_item.mark = dz_s3 || (!nneg_s3 && lhs_s3 >= rhs_s3);
	assign q_item.eof  = eof_s3;
	assign q_item.row  = row_s3;
	assign q_item.col  = col_s3;

endmodule

// ===== sv/rhm_fifo.sv =====
// ----------------------------------------------------------------------------
// rhm_fifo
// Short queue of classified pixels between the hue pipeline and the
// box accumulator.
// ----------------------------------------------------------------------------
module rhm_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           push_ready,
	input  rhm_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop,
	output rhm_pkg::item_t pop_item
);
	import rhm_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue occupancy beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CNT_W'(QUEUE_DEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with occupancy");
`endif

endmodule

// ===== sv/rhm_back.sv =====
// ----------------------------------------------------------------------------
// rhm_back
// Bounding box and match count accumulator with end-of-frame summary and
// aspect ratio check, two stages into a registered output.
// ----------------------------------------------------------------------------
module rhm_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rhm_pkg::cfg_t                  cfg,
	input  logic                           q_valid,
	output logic                           q_pop,
	input  rhm_pkg::item_t                 q_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           pixel_mask,
	output logic                           frame_done,
	output logic                           found,
	output logic                           aspect_ok,
	output logic [rhm_pkg::COORD_BITS-1:0] box_row_min,
	output logic [rhm_pkg::COORD_BITS-1:0] box_row_max,
	output logic [rhm_pkg::COORD_BITS-1:0] box_col_min,
	output logic [rhm_pkg::COORD_BITS-1:0] box_col_max,
	output logic [rhm_pkg::COUNT_BITS-1:0] match_total
);
	import rhm_pkg::*;

	localparam logic [COORD_BITS-1:0] COORD_ONES = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONES = '1;

	logic en_out, en_s1;

	logic [COORD_BITS-1:0] row_low_q, row_high_q, col_low_q, col_high_q;
	logic [COUNT_BITS-1:0] match_count_q;
	logic                  box_empty_q;

	logic [COORD_BITS-1:0] row_low_n, row_high_n, col_low_n, col_high_n;
	logic [COUNT_BITS-1:0] count_n;

	logic                  v_s1, mark_s1, eof_s1;
	logic [COORD_BITS-1:0] rlo_s1, rhi_s1, clo_s1, chi_s1;
	logic [COUNT_BITS-1:0] cnt_s1;

	logic                  out_valid_q, mask_q, done_q, found_q, aspect_q;
	logic [COORD_BITS-1:0] rlo_q, rhi_q, clo_q, chi_q;
	logic [COUNT_BITS-1:0] cnt_q;

	logic signed [SPAN_W-1:0] dr, dc;
	logic signed [ASP_W-1:0]  dr10, hi_dc, lo_dc;
	logic                     ratio_ok, found_n;

	assign en_out = !out_valid_q || out_ready;
	assign en_s1  = !v_s1 || en_out;
	assign q_pop  = q_valid && en_s1;

	always_comb begin
		row_low_n  = row_low_q;
		row_high_n = row_high_q;
		col_low_n  = col_low_q;
		col_high_n = col_high_q;
		count_n    = match_count_q;
		if (q_item.mark) begin
			if (q_item.row != '0 && q_item.row < row_low_q) begin
				row_low_n = q_item.row;
			end
			if (box_empty_q || q_item.row > row_high_q) begin
				row_high_n = q_item.row;
			end
			if (q_item.col != '0 && q_item.col < col_low_q) begin
				col_low_n = q_item.col;
			end
			if (box_empty_q || q_item.col > col_high_q) begin
				col_high_n = q_item.col;
			end
			if (match_count_q != COUNT_ONES) begin
				count_n = match_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_low_q     <= COORD_ONES;
			row_high_q    <= '0;
			col_low_q     <= COORD_ONES;
			col_high_q    <= '0;
			match_count_q <= '0;
			box_empty_q   <= 1'b1;
		end else if (q_pop) begin
			if (q_item.eof) begin
				row_low_q     <= COORD_ONES;
				row_high_q    <= '0;
				col_low_q     <= COORD_ONES;
				col_high_q    <= '0;
				match_count_q <= '0;
				box_empty_q   <= 1'b1;
			end else begin
				row_low_q     <= row_low_n;
				row_high_q    <= row_high_n;
				col_low_q     <= col_low_n;
				col_high_q    <= col_high_n;
				match_count_q <= count_n;
				box_empty_q   <= box_empty_q && !q_item.mark;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= q_pop;
			end
			if (en_out) begin
				out_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			mark_s1 <= q_item.mark;
			eof_s1  <= q_item.eof;
			rlo_s1  <= row_low_n;
			rhi_s1  <= row_high_n;
			clo_s1  <= col_low_n;
			chi_s1  <= col_high_n;
			cnt_s1  <= count_n;
		end
	end

	// spans are signed: an empty or one-sided box gives a negative span
	assign dr    = $signed({1'b0, rhi_s1}) - $signed({1'b0, rlo_s1});
	assign dc    = $signed({1'b0, chi_s1}) - $signed({1'b0, clo_s1});
	assign dr10  = ASP_W'(dr) * ASP_W'(10);
	assign hi_dc = $signed(ASP_W'(cfg.aspect_high_tenths)) * ASP_W'(dc);
	assign lo_dc = $signed(ASP_W'(cfg.aspect_low_tenths)) * ASP_W'(dc);
	assign ratio_ok = !dc[SPAN_W-1] && dc != '0 && dr10 <= hi_dc && dr10 >= lo_dc;
	assign found_n  = CNT_CMP_W'(cnt_s1) >= CNT_CMP_W'(cfg.min_matches);

	always_ff @(posedge clk) begin
		if (en_out && v_s1) begin
			mask_q   <= mark_s1;
			done_q   <= eof_s1;
			found_q  <= eof_s1 && found_n;
			aspect_q <= eof_s1 && ratio_ok;
			rlo_q    <= eof_s1 ? rlo_s1 : '0;
			rhi_q    <= eof_s1 ? rhi_s1 : '0;
			clo_q    <= eof_s1 ? clo_s1 : '0;
			chi_q    <= eof_s1 ? chi_s1 : '0;
			cnt_q    <= eof_s1 ? cnt_s1 : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_mask  = mask_q;
	assign frame_done  = done_q;
	assign found       = found_q;
	assign aspect_ok   = aspect_q;
	assign box_row_min = rlo_q;
	assign box_row_max = rhi_q;
	assign box_col_min = clo_q;
	assign box_col_max = chi_q;
	assign match_total = cnt_q;

`ifndef SYNTHESIS
	a_clear_after_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.eof) |=> (match_count_q == '0 && box_empty_q))
		else $error("frame state not cleared after end of frame");
	a_count_box: assert property (@(posedge clk) disable iff (!arst_n)
		match_count_q != '0 |-> !box_empty_q)
		else $error("matches counted with empty box");
	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !done_q) |-> (cnt_q == '0 && !found_q && !aspect_q))
		else $error("summary fields set on a mid-frame transaction");
`endif

endmodule

// ===== sv/red_hue_mask_bounding_box.sv =====
// ----------------------------------------------------------------------------
// red_hue_mask_bounding_box
// Red hue pixel mask with per-frame bounding box, match count and aspect
// check.
// ----------------------------------------------------------------------------
// One result transaction per pixel transaction, at a sustained rate of one
// pixel per clock while out_ready does not stall the output. A pixel passes
// through the three hue pipeline registers (operand products, d2 sum and
// numerator square, squared-cosine threshold multiply with the compare behind
// it), then a four-entry queue, the accumulator stage and the output register,
// where it shows its result. The 16x16 threshold multiply
// and the aspect multipliers each sit in a stage of their own. Frame summary
// fields are valid on the transaction whose frame_done is set; the frame state
// clears as the end-of-frame pixel is accumulated. Configuration writes take
// effect at once and belong between frames.
// ----------------------------------------------------------------------------
module red_hue_mask_bounding_box (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rhm_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [rhm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rhm_pkg::COORD_BITS-1:0]  pixel_row,
	input  logic [rhm_pkg::COORD_BITS-1:0]  pixel_col,
	input  logic [rhm_pkg::SAMPLE_BITS-1:0] red,
	input  logic [rhm_pkg::SAMPLE_BITS-1:0] green,
	input  logic [rhm_pkg::SAMPLE_BITS-1:0] blue,
	input  logic                            end_of_frame,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            pixel_mask,
	output logic                            frame_done,
	output logic                            found,
	output logic                            aspect_ok,
	output logic [rhm_pkg::COORD_BITS-1:0]  box_row_min,
	output logic [rhm_pkg::COORD_BITS-1:0]  box_row_max,
	output logic [rhm_pkg::COORD_BITS-1:0]  box_col_min,
	output logic [rhm_pkg::COORD_BITS-1:0]  box_col_max,
	output logic [rhm_pkg::COUNT_BITS-1:0]  match_total
);
	import rhm_pkg::*;

	cfg_t  cfg_q;
	logic  push, push_ready, pop_valid, pop;
	item_t push_item, pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cos_sq_low_hue     <= RST_COS_SQ_LOW;
			cfg_q.cos_sq_high_hue    <= RST_COS_SQ_HIGH;
			cfg_q.min_matches        <= RST_MIN_MATCHES;
			cfg_q.aspect_high_tenths <= RST_ASPECT_HIGH;
			cfg_q.aspect_low_tenths  <= RST_ASPECT_LOW;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_COS_SQ_LOW_HUE: begin
					cfg_q.cos_sq_low_hue <= cfg_wdata[COS_BITS-1:0];
				end
				CFG_COS_SQ_HIGH_HUE: begin
					cfg_q.cos_sq_high_hue <= cfg_wdata[COS_BITS-1:0];
				end
				CFG_MIN_MATCHES: begin
					cfg_q.min_matches <= cfg_wdata[MIN_BITS-1:0];
				end
				CFG_ASPECT_HIGH_TENTHS: begin
					cfg_q.aspect_high_tenths <= cfg_wdata[TENTHS_BITS-1:0];
				end
				CFG_ASPECT_LOW_TENTHS: begin
					cfg_q.aspect_low_tenths <= cfg_wdata[TENTHS_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	rhm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_row    (pixel_row),
		.pixel_col    (pixel_col),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.end_of_frame (end_of_frame),
		.cfg          (cfg_q),
		.q_push       (push),
		.q_item       (push_item),
		.q_ready      (push_ready)
	);

	rhm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item)
	);

	rhm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (pop_valid),
		.q_pop       (pop),
		.q_item      (pop_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_mask  (pixel_mask),
		.frame_done  (frame_done),
		.found       (found),
		.aspect_ok   (aspect_ok),
		.box_row_min (box_row_min),
		.box_row_max (box_row_max),
		.box_col_min (box_col_min),
		.box_col_max (box_col_max),
		.match_total (match_total)
	);

endmodule

// ===== sim/tb_red_hue_mask_bounding_box.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_red_hue_mask_bounding_box
// Self-checking bench for the red hue mask and frame bounding box block.
// ----------------------------------------------------------------------------
// Pixels are driven as frames over the valid/ready input channel. Each
// accepted transaction is run through a local hue and box model, and the
// result is queued. Each result transaction is checked field by field
// against the oldest queued entry. Directed pixels cover color extremes and
// the corner cases of the box. Register extremes and random frames follow,
// with sender and receiver idling applied in turn.
// ----------------------------------------------------------------------------
module tb_red_hue_mask_bounding_box;
	import rhm_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_ITEMS = 1700;
	localparam int PRINT_LIMIT  = 40;

	typedef struct {
		logic                  mask;
		logic                  done;
		logic                  found;
		logic                  aspect_ok;
		logic [COORD_BITS-1:0] row_min;
		logic [COORD_BITS-1:0] row_max;
		logic [COORD_BITS-1:0] col_min;
		logic [COORD_BITS-1:0] col_max;
		logic [COUNT_BITS-1:0] total;
	} pixel_result_t;

	typedef struct {
		logic [COORD_BITS-1:0] row_low;
		logic [COORD_BITS-1:0] row_high;
		logic [COORD_BITS-1:0] col_low;
		logic [COORD_BITS-1:0] col_high;
		logic [COUNT_BITS-1:0] count;
		logic                  empty;
	} frame_box_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_addr;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   in_valid;
	logic                   in_ready;
	logic [COORD_BITS-1:0]  pixel_row;
	logic [COORD_BITS-1:0]  pixel_col;
	logic [SAMPLE_BITS-1:0] red;
	logic [SAMPLE_BITS-1:0] green;
	logic [SAMPLE_BITS-1:0] blue;
	logic                   end_of_frame;
	logic                   out_valid;
	logic                   out_ready;
	logic                   pixel_mask;
	logic                   frame_done;
	logic                   found;
	logic                   aspect_ok;
	logic [COORD_BITS-1:0]  box_row_min;
	logic [COORD_BITS-1:0]  box_row_max;
	logic [COORD_BITS-1:0]  box_col_min;
	logic [COORD_BITS-1:0]  box_col_max;
	logic [COUNT_BITS-1:0]  match_total;

	cfg_t          hue_cfg;
	frame_box_t    frame_box;
	pixel_result_t pending_results[$];
	int            mismatch_count = 0;
	int            idle_pct = 0;
	int            stall_pct = 0;
	int            stall_run = 0;

	red_hue_mask_bounding_box uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_row    (pixel_row),
		.pixel_col    (pixel_col),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.end_of_frame (end_of_frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_mask   (pixel_mask),
		.frame_done   (frame_done),
		.found        (found),
		.aspect_ok    (aspect_ok),
		.box_row_min  (box_row_min),
		.box_row_max  (box_row_max),
		.box_col_min  (box_col_min),
		.box_col_max  (box_col_max),
		.match_total  (match_total)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// cos^2 test done in integers: n2^2 * 2^16 >= 4 * T * d2
	function automatic bit hue_in_red_band(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		longint n2;
		longint d2;
		longint thr;
		n2 = 2 * longint'(r) - longint'(g) - longint'(b);
		d2 = (longint'(r) - longint'(g)) * (longint'(r) - longint'(g)) +
			(longint'(r) - longint'(b)) * (longint'(g) - longint'(b));
		thr = (b > g) ? longint'(hue_cfg.cos_sq_high_hue) : longint'(hue_cfg.cos_sq_low_hue);
		if (d2 == 0)
			return 1'b1;
		if (n2 < 0)
			return 1'b0;
		return (n2 * n2 * 65536) >= (4 * thr * d2);
	endfunction

	function automatic void clear_frame_box();
		frame_box.row_low  = '1;
		frame_box.row_high = '0;
		frame_box.col_low  = '1;
		frame_box.col_high = '0;
		frame_box.count    = '0;
		frame_box.empty    = 1'b1;
	endfunction

	function automatic pixel_result_t accumulate_pixel(input logic [COORD_BITS-1:0] row,
		input logic [COORD_BITS-1:0] col, input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic eof);
		pixel_result_t res;
		longint dr;
		longint dc;
		res = '{default: '0};
		res.mask = hue_in_red_band(r, g, b);
		if (res.mask) begin
			if (row != 0 && row < frame_box.row_low)
				frame_box.row_low = row;
			if (frame_box.empty || row > frame_box.row_high)
				frame_box.row_high = row;
			if (col != 0 && col < frame_box.col_low)
				frame_box.col_low = col;
			if (frame_box.empty || col > frame_box.col_high)
				frame_box.col_high = col;
			if (frame_box.count != '1)
				frame_box.count = frame_box.count + 1'b1;
			frame_box.empty = 1'b0;
		end
		if (eof) begin
			dr = longint'(frame_box.row_high) - longint'(frame_box.row_low);
			dc = longint'(frame_box.col_high) - longint'(frame_box.col_low);
			res.done      = 1'b1;
			res.found     = (frame_box.count >= hue_cfg.min_matches);
			res.aspect_ok = (dc > 0) &&
				(10 * dr <= longint'(hue_cfg.aspect_high_tenths) * dc) &&
				(10 * dr >= longint'(hue_cfg.aspect_low_tenths) * dc);
			res.row_min   = frame_box.row_low;
			res.row_max   = frame_box.row_high;
			res.col_min   = frame_box.col_low;
			res.col_max   = frame_box.col_high;
			res.total     = frame_box.count;
			clear_frame_box();
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("[%0t] %s: got %h expected %h", $time, what, got, want);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	always @(posedge clk) begin : result_check
		pixel_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transaction with none pending", '0, '0);
			end else begin
				want = pending_results.pop_front();
				check_field("pixel_mask", pixel_mask, want.mask);
				check_field("frame_done", frame_done, want.done);
				check_field("found", found, want.found);
				check_field("aspect_ok", aspect_ok, want.aspect_ok);
				check_field("box_row_min", box_row_min, want.row_min);
				check_field("box_row_max", box_row_max, want.row_max);
				check_field("box_col_min", box_col_min, want.col_min);
				check_field("box_col_max", box_col_max, want.col_max);
				check_field("match_total", match_total, want.total);
			end
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_run <= 0;
		end else if (stall_run >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stall_run <= stall_run + 1;
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_pixel(input logic [COORD_BITS-1:0] row,
		input logic [COORD_BITS-1:0] col, input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic eof);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		pixel_row    <= row;
		pixel_col    <= col;
		red          <= r;
		green        <= g;
		blue         <= b;
		end_of_frame <= eof;
		do begin
			@(posedge clk);
		end while (!in_ready);
		pending_results.push_back(accumulate_pixel(row, col, r, g, b, eof));
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apply_config(input cfg_t next_cfg);
		cfg_idx_t idx;
		drain_results();
		idx = idx.first();
		repeat (idx.num()) begin
			cfg_we   <= 1'b1;
			cfg_addr <= idx;
			case (idx)
				CFG_COS_SQ_LOW_HUE:     cfg_wdata <= CFG_DATA_W'(next_cfg.cos_sq_low_hue);
				CFG_COS_SQ_HIGH_HUE:    cfg_wdata <= CFG_DATA_W'(next_cfg.cos_sq_high_hue);
				CFG_MIN_MATCHES:        cfg_wdata <= CFG_DATA_W'(next_cfg.min_matches);
				CFG_ASPECT_HIGH_TENTHS: cfg_wdata <= CFG_DATA_W'(next_cfg.aspect_high_tenths);
				default:                cfg_wdata <= CFG_DATA_W'(next_cfg.aspect_low_tenths);
			endcase
			@(negedge clk);
			idx = idx.next();
		end
		cfg_we  <= 1'b0;
		hue_cfg = next_cfg;
	endtask

	function automatic cfg_t random_config();
		cfg_t c;
		c.cos_sq_low_hue  = $urandom_range(1) ? RST_COS_SQ_LOW : COS_BITS'($urandom_range(65535));
		c.cos_sq_high_hue = $urandom_range(1) ? RST_COS_SQ_HIGH : COS_BITS'($urandom_range(65535));
		c.min_matches     = ($urandom_range(7) == 0) ? MIN_BITS'($urandom_range(16777215)) :
			MIN_BITS'($urandom_range(40));
		c.aspect_low_tenths  = TENTHS_BITS'($urandom_range(12));
		c.aspect_high_tenths = c.aspect_low_tenths + TENTHS_BITS'($urandom_range(12));
		return c;
	endfunction

	// mostly reddish pixels, some gray, some near the band edge, rest noise
	task automatic pick_color(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
		int kind;
		kind = $urandom_range(99);
		if (kind < 45) begin
			r = 8'($urandom_range(255, 40));
			g = 8'($urandom_range(r / 6));
			b = 8'($urandom_range(r / 6));
		end else if (kind < 60) begin
			r = 8'($urandom_range(255));
			g = r;
			b = r;
		end else if (kind < 70) begin
			r = 8'd255;
			g = 8'($urandom_range(60));
			b = 8'($urandom_range(60));
		end else begin
			r = 8'($urandom_range(255));
			g = 8'($urandom_range(255));
			b = 8'($urandom_range(255));
		end
	endtask

	task automatic run_frame(input int pixels, input bit windowed);
		logic [COORD_BITS-1:0] r0;
		logic [COORD_BITS-1:0] c0;
		logic [COORD_BITS-1:0] rows;
		logic [COORD_BITS-1:0] cols;
		logic [COORD_BITS-1:0] row;
		logic [COORD_BITS-1:0] col;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		rows = COORD_BITS'($urandom_range(40));
		cols = COORD_BITS'((rows * $urandom_range(13, 8)) / 10 + 1);
		r0 = ($urandom_range(7) == 0) ? '0 : COORD_BITS'($urandom_range(4095));
		c0 = ($urandom_range(7) == 0) ? '0 : COORD_BITS'($urandom_range(4095));
		for (int i = 0; i < pixels; i++) begin
			if (windowed) begin
				row = r0 + COORD_BITS'($urandom_range(rows));
				col = c0 + COORD_BITS'($urandom_range(cols));
			end else begin
				row = COORD_BITS'($urandom_range(4095));
				col = COORD_BITS'($urandom_range(4095));
			end
			pick_color(r, g, b);
			send_pixel(row, col, r, g, b, i == pixels - 1);
		end
	endtask

	task automatic test_directed_pixels();
		send_pixel(0, 0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(4095, 4095, 8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(1, 1, 8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(2, 4094, 8'd0, 8'd255, 8'd0, 1'b0);
		send_pixel(2048, 2048, 8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(100, 200, 8'd255, 8'd0, 8'd255, 1'b0);
		send_pixel(101, 201, 8'd255, 8'd255, 8'd0, 1'b0);
		send_pixel(102, 202, 8'd255, 8'd0, 8'd8, 1'b0);
		send_pixel(103, 203, 8'd255, 8'd8, 8'd0, 1'b0);
		send_pixel(0, 0, 8'd0, 8'd255, 8'd255, 1'b1);
	endtask

	task automatic test_special_cases();
		// marks on row 0 only: row span goes negative
		send_pixel(0, 10, 8'd200, 8'd0, 8'd0, 1'b0);
		send_pixel(0, 40, 8'd200, 8'd0, 8'd0, 1'b1);
		// nothing marked
		send_pixel(7, 7, 8'd0, 8'd255, 8'd0, 1'b1);
		// square box, ratio inside bounds
		send_pixel(10, 10, 8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(20, 20, 8'd255, 8'd0, 8'd0, 1'b1);
		// zero column span
		send_pixel(5, 7, 8'd255, 8'd0, 8'd0, 1'b0);
		send_pixel(9, 7, 8'd128, 8'd128, 8'd128, 1'b1);
	endtask

	task automatic test_register_extremes();
		cfg_t c;
		c = '{cos_sq_low_hue: '0, cos_sq_high_hue: '0, min_matches: '0,
			aspect_high_tenths: 8'd255, aspect_low_tenths: 8'd0};
		apply_config(c);
		run_frame(16, 1'b1);
		run_frame(8, 1'b0);
		send_pixel(0, 5, 8'd255, 8'd0, 8'd0, 1'b1);
		c = '{cos_sq_low_hue: '1, cos_sq_high_hue: '1, min_matches: '1,
			aspect_high_tenths: 8'd0, aspect_low_tenths: 8'd255};
		apply_config(c);
		run_frame(16, 1'b1);
		run_frame(8, 1'b0);
		c = '{cos_sq_low_hue: RST_COS_SQ_LOW, cos_sq_high_hue: RST_COS_SQ_HIGH,
			min_matches: MIN_BITS'(3), aspect_high_tenths: RST_ASPECT_HIGH,
			aspect_low_tenths: RST_ASPECT_LOW};
		apply_config(c);
		run_frame(16, 1'b1);
	endtask

	task automatic test_random_frames(input int sender_idle, input int receiver_stall,
		input int items);
		int sent;
		int n;
		sent = 0;
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		apply_config(random_config());
		while (sent < items) begin
			if ($urandom_range(4) == 0)
				apply_config(random_config());
			n = ($urandom_range(9) == 0) ? $urandom_range(120, 60) : $urandom_range(40, 1);
			run_frame(n, $urandom_range(99) < 75);
			sent += n;
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_addr     = CFG_COS_SQ_LOW_HUE;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		pixel_row    = '0;
		pixel_col    = '0;
		red          = '0;
		green        = '0;
		blue         = '0;
		end_of_frame = 1'b0;
		out_ready    = 1'b0;
		hue_cfg = '{cos_sq_low_hue: RST_COS_SQ_LOW, cos_sq_high_hue: RST_COS_SQ_HIGH,
			min_matches: RST_MIN_MATCHES, aspect_high_tenths: RST_ASPECT_HIGH,
			aspect_low_tenths: RST_ASPECT_LOW};
		clear_frame_box();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_pixels();
		test_special_cases();
		test_register_extremes();
		test_random_frames(0, 0, RANDOM_ITEMS / 4);
		test_random_frames(76, 0, RANDOM_ITEMS / 4);
		test_random_frames(0, 76, RANDOM_ITEMS / 4);
		test_random_frames(37, 37, RANDOM_ITEMS / 4);
		drain_results();

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
